@@ rtl/positional_list_buffer_macros.svh @@
// assertion macros for the positional list buffer checker
// depends on nothing; taken in by the checker through `include
`ifndef POSITIONAL_LIST_BUFFER_MACROS_SVH
`define POSITIONAL_LIST_BUFFER_MACROS_SVH

// assertion that is checked at every edge, reset included
`define PLB_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// assertion that is switched off while reset is high
`define PLB_ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/plb_pkg.sv @@
// shared constants and types of the positional list buffer
// depends on nothing; used by every rtl file of the block but the macro header
package plb_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPCODE_WIDTH      = 3;
   localparam int VALUE_WIDTH       = 32;
   localparam int POSITION_WIDTH    = 6;
   localparam int STATUS_WIDTH      = 2;
   localparam int ENTRY_COUNT_WIDTH = 5;
   localparam int ELEMENT_WIDTH     = 32;

   typedef logic [OPCODE_WIDTH-1:0] opcode_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   // operation codes
   localparam opcode_type OP_INS_FRONT = 3'd0;
   localparam opcode_type OP_INS_BACK  = 3'd1;
   localparam opcode_type OP_INS_POS   = 3'd2;
   localparam opcode_type OP_DEL_FRONT = 3'd3;
   localparam opcode_type OP_DEL_BACK  = 3'd4;
   localparam opcode_type OP_DEL_POS   = 3'd5;
   localparam opcode_type OP_DUMP      = 3'd6;

   // result status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BADPOS = 2'd1;
   localparam status_type ST_FULL   = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

   // what a cell loads at the next edge
   typedef logic [2:0] cell_cmd_type;
   localparam cell_cmd_type CELL_HOLD      = 3'd0;
   localparam cell_cmd_type CELL_LOAD      = 3'd1;
   localparam cell_cmd_type CELL_FROM_PREV = 3'd2;
   localparam cell_cmd_type CELL_FROM_NEXT = 3'd3;
   localparam cell_cmd_type CELL_FROM_HEAD = 3'd4;

   typedef struct packed {
      cell_cmd_type cmd;
   } cell_ctl_type;

endpackage

@@ rtl/positional_list_buffer.sv @@
// positional list buffer: a row of plb_cell elements and the control around it
// depends on plb_pkg and plb_cell
//
// The block holds an ordered list of up to DEPTH values of DATA_WIDTH bits in
// a chain of cells plus an element count. Each request transaction carries an
// opcode: insert at the front, at the back or at a 1-based position, delete at
// the front, at the back or at a 1-based position, or dump. Every edit gives
// one response transaction with a status (ok, invalid position, list full,
// list empty), the element count after the edit, element zero and
// last_result set; refused edits leave the list unchanged. In an edit all
// cells move in parallel, each loading the new value or the value of a
// neighbour, so edits follow back to back as long as the response side keeps
// up. A dump of n elements enters the dump state, then gives one response per
// cycle while the output is not stalled, as the chain rotates one place
// forward per delivered element and the head cell feeds the single response
// register; after n steps the list is back in its original order. Requests
// are stalled during a dump and while a response waits on a stalled output.
// A dump of an empty list gives one response with status list empty. The
// cells have no reset: only cells below the count are ever read. Values wider
// than DATA_WIDTH keep their low bits; the count is reported in five bits.
module positional_list_buffer #(
   parameter int DEPTH      = plb_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = plb_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [plb_pkg::OPCODE_WIDTH-1:0]       req_opcode,
   input  logic [plb_pkg::VALUE_WIDTH-1:0]        req_value,
   input  logic [plb_pkg::POSITION_WIDTH-1:0]     req_position,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [plb_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [plb_pkg::ENTRY_COUNT_WIDTH-1:0]  rsp_entry_count,
   output logic [plb_pkg::ELEMENT_WIDTH-1:0]      rsp_element,
   output logic                                   rsp_last_result
);

   // count width, and a compare width that holds count+1 and any position
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > plb_pkg::POSITION_WIDTH) ? CW : plb_pkg::POSITION_WIDTH) + 1;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_DUMP = 1'b1;

   // control state
   logic          state_ff,     state_in;
   logic [CW-1:0] count_ff,     count_in;
   logic [CW-1:0] dump_left_ff, dump_left_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // response payload
   logic [plb_pkg::STATUS_WIDTH-1:0]      status_ff,  status_in;
   logic [plb_pkg::ENTRY_COUNT_WIDTH-1:0] ecount_ff,  ecount_in;
   logic [plb_pkg::ELEMENT_WIDTH-1:0]     element_ff, element_in;
   logic                                  last_ff,    last_in;

   // handshake
   logic out_free;
   logic accept;
   logic dump_step;

   // edit decode
   logic                             do_ins;
   logic                             do_del;
   logic                             is_dump;
   logic [plb_pkg::STATUS_WIDTH-1:0] edit_status;
   logic [CMPW-1:0]                  ins_idx;
   logic [CMPW-1:0]                  del_idx;
   logic [CMPW-1:0]                  pos_ext;
   logic [CMPW-1:0]                  cnt_ext;
   logic                             full;
   logic                             empty;

   // width adaption
   logic [DATA_WIDTH+plb_pkg::VALUE_WIDTH-1:0]     value_wide;
   logic [DATA_WIDTH-1:0]                          load_data;
   logic [DATA_WIDTH+plb_pkg::ELEMENT_WIDTH-1:0]   head_wide;
   logic [CW+plb_pkg::ENTRY_COUNT_WIDTH-1:0]       count_wide;

   // cell chain
   logic [DATA_WIDTH-1:0]  cell_data [DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != STATE_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign dump_step = (state_ff == STATE_DUMP) && out_free;

   assign pos_ext = CMPW'(req_position);
   assign cnt_ext = CMPW'(count_ff);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);

   // new value kept in its low DATA_WIDTH bits
   assign value_wide = {{DATA_WIDTH{1'b0}}, req_value};
   assign load_data  = value_wide[DATA_WIDTH-1:0];

   // head cell feeds the response element, zero extended or truncated
   assign head_wide = {{plb_pkg::ELEMENT_WIDTH{1'b0}}, cell_data[0]};

   // decode one edit: status, and where the chain opens or closes
   always_comb begin
      do_ins      = 1'b0;
      do_del      = 1'b0;
      is_dump     = 1'b0;
      edit_status = plb_pkg::ST_OK;
      ins_idx     = '0;
      del_idx     = '0;
      unique case (req_opcode) inside
         plb_pkg::OP_INS_FRONT, plb_pkg::OP_INS_BACK, plb_pkg::OP_INS_POS: begin
            // full check comes before the position check
            if (full) begin
               edit_status = plb_pkg::ST_FULL;
            end else if (req_opcode == plb_pkg::OP_INS_FRONT) begin
               do_ins = 1'b1;
            end else if (req_opcode == plb_pkg::OP_INS_BACK) begin
               do_ins  = 1'b1;
               ins_idx = cnt_ext;
            end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
               edit_status = plb_pkg::ST_BADPOS;
            end else begin
               do_ins  = 1'b1;
               ins_idx = pos_ext - CMPW'(1);
            end
         end
         plb_pkg::OP_DEL_FRONT, plb_pkg::OP_DEL_BACK, plb_pkg::OP_DEL_POS: begin
            // empty check comes before the position check
            if (empty) begin
               edit_status = plb_pkg::ST_EMPTY;
            end else if (req_opcode == plb_pkg::OP_DEL_FRONT) begin
               do_del = 1'b1;
            end else if (req_opcode == plb_pkg::OP_DEL_BACK) begin
               do_del  = 1'b1;
               del_idx = cnt_ext - CMPW'(1);
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
               edit_status = plb_pkg::ST_BADPOS;
            end else begin
               do_del  = 1'b1;
               del_idx = pos_ext - CMPW'(1);
            end
         end
         plb_pkg::OP_DUMP: begin
            is_dump = 1'b1;
         end
         default: begin
            // unused opcode: no change, plain ok response
            edit_status = plb_pkg::ST_OK;
         end
      endcase
   end

   // the chain of cells, each told by its own index what to load
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMPW-1:0] IDX  = CMPW'(i);
      localparam logic [CMPW-1:0] IDX1 = CMPW'(i + 1);

      logic [DATA_WIDTH-1:0] prev_data;
      logic [DATA_WIDTH-1:0] next_data;
      plb_pkg::cell_ctl_type ctl;

      if (i == 0) begin : g_first
         assign prev_data = load_data;
      end else begin : g_inner_prev
         assign prev_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_inner_next
         assign next_data = cell_data[i+1];
      end

      always_comb begin
         ctl.cmd = plb_pkg::CELL_HOLD;
         if (accept && do_ins) begin
            // open a gap at the insert point, later entries move back
            if (IDX == ins_idx) begin
               ctl.cmd = plb_pkg::CELL_LOAD;
            end else if (IDX > ins_idx && IDX <= cnt_ext) begin
               ctl.cmd = plb_pkg::CELL_FROM_PREV;
            end
         end else if (accept && do_del) begin
            // close the gap, later entries move forward
            if (IDX >= del_idx && IDX1 < cnt_ext) begin
               ctl.cmd = plb_pkg::CELL_FROM_NEXT;
            end
         end else if (dump_step) begin
            // rotate the stored part of the chain by one place
            if (IDX1 < cnt_ext) begin
               ctl.cmd = plb_pkg::CELL_FROM_NEXT;
            end else if (IDX1 == cnt_ext) begin
               ctl.cmd = plb_pkg::CELL_FROM_HEAD;
            end
         end
      end

      plb_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (load_data),
         .prev_data (prev_data),
         .next_data (next_data),
         .head_data (cell_data[0]),
         .data      (cell_data[i])
      );
   end

   // count after this cycle's edit
   always_comb begin
      count_in = count_ff;
      if (accept && do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (accept && do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_wide = {{plb_pkg::ENTRY_COUNT_WIDTH{1'b0}}, count_in};

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      dump_left_in = dump_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      ecount_in    = ecount_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      if (accept) begin
         if (is_dump && !empty) begin
            // responses come from the head cell in the following cycles
            state_in     = STATE_DUMP;
            dump_left_in = count_ff;
         end else begin
            rsp_valid_in = 1'b1;
            status_in    = is_dump ? plb_pkg::ST_EMPTY : edit_status;
            ecount_in    = count_wide[plb_pkg::ENTRY_COUNT_WIDTH-1:0];
            element_in   = '0;
            last_in      = 1'b1;
         end
      end else if (dump_step) begin
         rsp_valid_in = 1'b1;
         status_in    = plb_pkg::ST_OK;
         ecount_in    = count_wide[plb_pkg::ENTRY_COUNT_WIDTH-1:0];
         element_in   = head_wide[plb_pkg::ELEMENT_WIDTH-1:0];
         last_in      = (dump_left_ff == CW'(1));
         dump_left_in = dump_left_ff - CW'(1);
         if (dump_left_ff == CW'(1)) begin
            state_in = STATE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      ecount_ff  <= ecount_in;
      element_ff <= element_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = ecount_ff;
   assign rsp_element     = element_ff;
   assign rsp_last_result = last_ff;

endmodule

@@ rtl/plb_cell.sv @@
// one storage cell of the positional list buffer chain
// depends on plb_pkg
module plb_cell #(
   parameter int DATA_WIDTH = plb_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  plb_pkg::cell_ctl_type  ctl,
   input  logic [DATA_WIDTH-1:0]  load_data,
   input  logic [DATA_WIDTH-1:0]  prev_data,
   input  logic [DATA_WIDTH-1:0]  next_data,
   input  logic [DATA_WIDTH-1:0]  head_data,
   output logic [DATA_WIDTH-1:0]  data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      unique case (ctl.cmd)
         plb_pkg::CELL_LOAD:      data_in = load_data;
         plb_pkg::CELL_FROM_PREV: data_in = prev_data;
         plb_pkg::CELL_FROM_NEXT: data_in = next_data;
         plb_pkg::CELL_FROM_HEAD: data_in = head_data;
         default:                 data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ rtl/plb_checker.sv @@
// port level checks for the positional list buffer, bound to the top level
// depends on plb_pkg and positional_list_buffer_macros.svh
`include "positional_list_buffer_macros.svh"

module plb_checker #(
   parameter int DEPTH = plb_pkg::DEPTH_DEFAULT
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [plb_pkg::STATUS_WIDTH-1:0]       rsp_status,
   input logic [plb_pkg::ENTRY_COUNT_WIDTH-1:0]  rsp_entry_count,
   input logic [plb_pkg::ELEMENT_WIDTH-1:0]      rsp_element,
   input logic                                   rsp_last_result
);

   // no response straight after reset
   `PLB_ASSERT(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response holds
   `PLB_ASSERT_DIS(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_element) && $stable(rsp_last_result) && $stable(rsp_entry_count), "stalled response changed")

   // only the last response of a dump can carry a non-ok status
   `PLB_ASSERT_DIS(a_mid_dump_ok, clock, reset, rsp_valid && !rsp_last_result |-> rsp_status == plb_pkg::ST_OK, "error status inside a dump")

   // refused or empty results never show an element
   `PLB_ASSERT_DIS(a_err_no_elem, clock, reset, rsp_valid && rsp_status != plb_pkg::ST_OK |-> rsp_element == '0, "element on error response")

   // a full refusal reports a full list
   `PLB_ASSERT_DIS(a_full_count, clock, reset, rsp_valid && rsp_status == plb_pkg::ST_FULL |-> rsp_entry_count == plb_pkg::ENTRY_COUNT_WIDTH'(DEPTH), "list full with wrong count")

endmodule

bind positional_list_buffer plb_checker #(
   .DEPTH (DEPTH)
) u_plb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_element     (rsp_element),
   .rsp_last_result (rsp_last_result)
);
